// File: design/gbs_pkg.sv
// Shared types, constants and helper functions for the gravity body step core.
package gbs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int DT_W          = 16;
    localparam int CUT_W         = 16;
    localparam int ACC_W         = 64;
    localparam int ROOT_W        = 33;
    localparam int RAD_W         = 66;
    localparam int SQRT_STEPS    = 33;
    localparam int MDT_W         = 48;
    localparam int DV_W          = 41;
    localparam int PROD_W        = MDT_W + ACC_W;
    localparam int DT_FRAC       = 16;

    localparam logic signed [WORD_W-1:0] ATTR_X_RST   = 32'sd62914560;
    localparam logic signed [WORD_W-1:0] ATTR_Y_RST   = 32'sd35389440;
    localparam logic [WORD_W-1:0]        STRENGTH_RST = 32'd10000000;
    localparam logic [CUT_W-1:0]         CUTOFF_RST   = 16'd100;
    localparam logic signed [WORD_W-1:0] BODY_X_RST   = 32'sd31457280;
    localparam logic signed [WORD_W-1:0] BODY_Y_RST   = 32'sd17694720;
    localparam logic signed [WORD_W-1:0] BODY_VX_RST  = 32'sd2621440;
    localparam logic signed [WORD_W-1:0] BODY_VY_RST  = 32'sd655360;

    localparam logic [1:0] CFG_ATTR_X   = 2'd0;
    localparam logic [1:0] CFG_ATTR_Y   = 2'd1;
    localparam logic [1:0] CFG_STRENGTH = 2'd2;
    localparam logic [1:0] CFG_CUTOFF   = 2'd3;

    localparam logic OPC_STEP = 1'b0;
    localparam logic OPC_LOAD = 1'b1;

    typedef enum logic [1:0] {
        OP_DIV,
        OP_SQRT,
        OP_MUL
    } gbs_op_t;

    typedef struct packed {
        logic    start;
        gbs_op_t op;
    } gbs_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_ROOT,
        ST_DIV1,
        ST_DIV2,
        ST_MDT,
        ST_MULA,
        ST_MULW,
        ST_DV,
        ST_MV_MUL,
        ST_MV_ADD,
        ST_OUT
    } gbs_state_t;

    function automatic int unit_width(input int frac);
        if (PROD_W > WORD_W + 3 * frac) begin
            return PROD_W;
        end
        return WORD_W + 3 * frac;
    endfunction

    function automatic logic [WORD_W:0] sat_word(input logic signed [42:0] v);
        if (v > 43'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (v < -43'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[WORD_W-1:0]};
    endfunction

endpackage

// File: design/gbs_iter_unit.sv
// Shared iterative unit: restoring divide, integer square root and shift-add multiply.
module gbs_iter_unit #(
    parameter int DW = 112
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  gbs_pkg::gbs_cmd_t cmd,
    input  logic [DW-1:0]     src_in,
    input  logic [DW-1:0]     dvs_in,
    output logic [DW-1:0]     quo,
    output logic [DW-1:0]     rem,
    output logic              done
);
    import gbs_pkg::*;

    localparam int CNT_W = $clog2(DW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    gbs_op_t         op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]   src_reg, src_next;
    logic [DW-1:0]   dvs_reg, dvs_next;
    logic [DW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   rem_reg, rem_next;

    logic [DW-1:0] shift_1, shift_2, trial, mul_sum, cmp_a, cmp_b, diff;
    logic          ge;

    always_comb begin
        shift_1 = {rem_reg[DW-2:0], src_reg[DW-1]};
        shift_2 = {rem_reg[DW-3:0], src_reg[DW-1:DW-2]};
        trial   = {quo_reg[DW-3:0], 2'b01};
        mul_sum = {rem_reg[DW-2:0], 1'b0} + (src_reg[DW-1] ? dvs_reg : '0);
        cmp_a   = (op_reg == OP_SQRT) ? shift_2 : shift_1;
        cmp_b   = (op_reg == OP_SQRT) ? trial : dvs_reg;
        diff    = cmp_a - cmp_b;
        ge      = (cmp_a >= cmp_b);

        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        src_next  = src_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;

        if (cmd.start) begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            src_next  = src_in;
            dvs_next  = dvs_in;
            quo_next  = '0;
            rem_next  = '0;
            unique case (cmd.op)
                OP_DIV:  cnt_next = CNT_W'(DW);
                OP_SQRT: cnt_next = CNT_W'(SQRT_STEPS);
                OP_MUL:  cnt_next = CNT_W'(ACC_W);
                default: cnt_next = CNT_W'(1);
            endcase
        end else if (busy_reg) begin
            unique case (op_reg)
                OP_DIV: begin
                    rem_next = ge ? diff : cmp_a;
                    quo_next = {quo_reg[DW-2:0], ge};
                    src_next = {src_reg[DW-2:0], 1'b0};
                end
                OP_SQRT: begin
                    rem_next = ge ? diff : cmp_a;
                    quo_next = {quo_reg[DW-2:0], ge};
                    src_next = {src_reg[DW-3:0], 2'b00};
                end
                OP_MUL: begin
                    rem_next = mul_sum;
                    src_next = {src_reg[DW-2:0], 1'b0};
                end
                default: begin
                    rem_next = rem_reg;
                end
            endcase
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_DIV;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg <= src_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

// File: design/gravity_body_step_core.sv
// Top level of the gravity body step core: sequencer, body state and configuration registers.
// The core holds one body's position and velocity in signed fixed point and steps it
// toward a fixed attractor with semi-implicit Euler integration.
// An input beat on the s_ channel either loads the body state (opcode 1) or advances
// one time step (opcode 0). Every input beat yields exactly one result beat on the
// m_ channel carrying the new state and the pulled and saturated flags.
// Configuration writes on the cfg_ channel are always ready and should be made while idle.
// A load offers its result in the cycle after acceptance. A step without pull spends
// most of its time in the 33-step square root; a step with pull spends most of it in
// the shared bit-serial unit that runs the two acceleration divides and, per axis,
// one 64-step multiply and one divide. One item is in flight at a time; s_ready is
// high only while idle, which begins in the cycle after the result beat is taken.
// The result is held on the m_ ports until m_ready is high; a stalled receiver holds the core.
// Reset (synchronous, active low) restores the default attractor, strength, cutoff and body state.
module gravity_body_step_core #(
    parameter int FRAC_BITS = gbs_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [15:0] s_time_step,
    input  logic signed [31:0] s_load_x,
    input  logic signed [31:0] s_load_y,
    input  logic signed [31:0] s_load_vx,
    input  logic signed [31:0] s_load_vy,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic signed [31:0] m_vel_x,
    output logic signed [31:0] m_vel_y,
    output logic        m_pulled,
    output logic        m_saturated,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import gbs_pkg::*;

    localparam int DW    = unit_width(FRAC_BITS);
    localparam int SA    = 3 * FRAC_BITS;
    localparam int CMP_W = ROOT_W + CUT_W + FRAC_BITS;

    gbs_state_t state_reg, state_next;

    logic signed [31:0] ax_reg, ay_reg;
    logic [31:0]        str_reg;
    logic [CUT_W-1:0]   cut_reg;
    logic signed [31:0] bx_reg, bx_next, by_reg, by_next;
    logic signed [31:0] bvx_reg, bvx_next, bvy_reg, bvy_next;
    logic [DT_W-1:0]    dt_reg, dt_next;
    logic [32:0]        dx_reg, dx_next, dy_reg, dy_next;
    logic [31:0]        ux_reg, ux_next, uy_reg, uy_next;
    logic [63:0]        sq_reg, sq_next, prod_reg;
    logic [ROOT_W-1:0]  r_reg, r_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               axis_reg, axis_next;
    logic               pulled_reg, pulled_next, sat_reg, sat_next;

    logic [31:0]   mul_a, mul_b;
    gbs_cmd_t      cmd;
    logic [DW-1:0] src_in, dvs_in, unit_quo, unit_rem;
    logic          unit_done;

    logic [32:0]        dxn, dyn, dxneg, dyneg;
    logic [64:0]        rad;
    logic [ROOT_W-1:0]  r_now;
    logic [CMP_W-1:0]   cut_sh;
    logic [DV_W-1:0]    dv;
    logic signed [31:0] v_cur, p_cur;
    logic [31:0]        v_mag, step_mag;
    logic               d_neg;
    logic signed [42:0] v43, dv43, vsum, p43, st43, psum;
    logic [32:0]        clip_res;

    gbs_iter_unit #(
        .DW(DW)
    ) u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .src_in  (src_in),
        .dvs_in  (dvs_in),
        .quo     (unit_quo),
        .rem     (unit_rem),
        .done    (unit_done)
    );

    always_comb begin
        dxn   = {ax_reg[31], ax_reg} - {bx_reg[31], bx_reg};
        dyn   = {ay_reg[31], ay_reg} - {by_reg[31], by_reg};
        dxneg = -dxn;
        dyneg = -dyn;
        rad   = {1'b0, sq_reg} + {1'b0, prod_reg};
        r_now = unit_quo[ROOT_W-1:0];
        cut_sh = CMP_W'(cut_reg) << FRAC_BITS;
        dv = ((|unit_quo[DW-1:57]) || (unit_quo[56:16] > {1'b1, 40'd0})) ?
             {1'b1, 40'd0} : unit_quo[56:16];
        v_cur = axis_reg ? bvy_reg : bvx_reg;
        p_cur = axis_reg ? by_reg : bx_reg;
        v_mag = v_cur[31] ? (32'd0 - v_cur) : v_cur;
        d_neg = axis_reg ? dy_reg[32] : dx_reg[32];
        v43   = {{11{v_cur[31]}}, v_cur};
        dv43  = {2'b00, dv};
        vsum  = d_neg ? (v43 - dv43) : (v43 + dv43);
        step_mag = prod_reg[47:16];
        p43   = {{11{p_cur[31]}}, p_cur};
        st43  = {11'd0, step_mag};
        psum  = v_cur[31] ? (p43 - st43) : (p43 + st43);

        state_next  = state_reg;
        bx_next     = bx_reg;
        by_next     = by_reg;
        bvx_next    = bvx_reg;
        bvy_next    = bvy_reg;
        dt_next     = dt_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        ux_next     = ux_reg;
        uy_next     = uy_reg;
        sq_next     = sq_reg;
        r_next      = r_reg;
        acc_next    = acc_reg;
        axis_next   = axis_reg;
        pulled_next = pulled_reg;
        sat_next    = sat_reg;
        mul_a       = '0;
        mul_b       = '0;
        cmd.start   = 1'b0;
        cmd.op      = OP_DIV;
        src_in      = '0;
        dvs_in      = '0;
        clip_res    = '0;
        s_ready     = 1'b0;
        m_valid     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    pulled_next = 1'b0;
                    sat_next    = 1'b0;
                    if (s_opcode == OPC_LOAD) begin
                        bx_next    = s_load_x;
                        by_next    = s_load_y;
                        bvx_next   = s_load_vx;
                        bvy_next   = s_load_vy;
                        state_next = ST_OUT;
                    end else begin
                        dt_next    = s_time_step;
                        state_next = ST_DIFF;
                    end
                end
            end
            ST_DIFF: begin
                dx_next    = dxn;
                dy_next    = dyn;
                ux_next    = dxn[32] ? dxneg[31:0] : dxn[31:0];
                uy_next    = dyn[32] ? dyneg[31:0] : dyn[31:0];
                state_next = ST_SQX;
            end
            ST_SQX: begin
                mul_a      = ux_reg;
                mul_b      = ux_reg;
                state_next = ST_SQY;
            end
            ST_SQY: begin
                sq_next    = prod_reg;
                mul_a      = uy_reg;
                mul_b      = uy_reg;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.start  = 1'b1;
                cmd.op     = OP_SQRT;
                src_in     = {1'b0, rad, {(DW-RAD_W){1'b0}}};
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (unit_done) begin
                    r_next = r_now;
                    axis_next = 1'b0;
                    if ((r_now != '0) && (CMP_W'(r_now) >= cut_sh)) begin
                        pulled_next = 1'b1;
                        cmd.start   = 1'b1;
                        cmd.op      = OP_DIV;
                        src_in      = DW'(str_reg) << SA;
                        dvs_in      = DW'(r_now);
                        state_next  = ST_DIV1;
                    end else begin
                        state_next = ST_MV_MUL;
                    end
                end
            end
            ST_DIV1: begin
                if (unit_done) begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_DIV;
                    src_in     = unit_quo;
                    dvs_in     = DW'(r_reg);
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (unit_done) begin
                    acc_next   = (|unit_quo[DW-1:ACC_W]) ? '1 : unit_quo[ACC_W-1:0];
                    axis_next  = 1'b0;
                    state_next = ST_MDT;
                end
            end
            ST_MDT: begin
                mul_a      = axis_reg ? uy_reg : ux_reg;
                mul_b      = 32'(dt_reg);
                state_next = ST_MULA;
            end
            ST_MULA: begin
                cmd.start  = 1'b1;
                cmd.op     = OP_MUL;
                src_in     = {acc_reg, {(DW-ACC_W){1'b0}}};
                dvs_in     = DW'(prod_reg[MDT_W-1:0]);
                state_next = ST_MULW;
            end
            ST_MULW: begin
                if (unit_done) begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_DIV;
                    src_in     = unit_rem;
                    dvs_in     = DW'(r_reg);
                    state_next = ST_DV;
                end
            end
            ST_DV: begin
                if (unit_done) begin
                    clip_res = sat_word(vsum);
                    sat_next = sat_reg | clip_res[32];
                    if (axis_reg) begin
                        bvy_next   = clip_res[31:0];
                        axis_next  = 1'b0;
                        state_next = ST_MV_MUL;
                    end else begin
                        bvx_next   = clip_res[31:0];
                        axis_next  = 1'b1;
                        state_next = ST_MDT;
                    end
                end
            end
            ST_MV_MUL: begin
                mul_a      = v_mag;
                mul_b      = 32'(dt_reg);
                state_next = ST_MV_ADD;
            end
            ST_MV_ADD: begin
                clip_res = sat_word(psum);
                sat_next = sat_reg | clip_res[32];
                if (axis_reg) begin
                    by_next    = clip_res[31:0];
                    axis_next  = 1'b0;
                    state_next = ST_OUT;
                end else begin
                    bx_next    = clip_res[31:0];
                    axis_next  = 1'b1;
                    state_next = ST_MV_MUL;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ax_reg     <= ATTR_X_RST;
            ay_reg     <= ATTR_Y_RST;
            str_reg    <= STRENGTH_RST;
            cut_reg    <= CUTOFF_RST;
            bx_reg     <= BODY_X_RST;
            by_reg     <= BODY_Y_RST;
            bvx_reg    <= BODY_VX_RST;
            bvy_reg    <= BODY_VY_RST;
            axis_reg   <= 1'b0;
            pulled_reg <= 1'b0;
            sat_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            bx_reg     <= bx_next;
            by_reg     <= by_next;
            bvx_reg    <= bvx_next;
            bvy_reg    <= bvy_next;
            axis_reg   <= axis_next;
            pulled_reg <= pulled_next;
            sat_reg    <= sat_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_ATTR_X:   ax_reg  <= cfg_data;
                    CFG_ATTR_Y:   ay_reg  <= cfg_data;
                    CFG_STRENGTH: str_reg <= cfg_data;
                    CFG_CUTOFF:   cut_reg <= cfg_data[CUT_W-1:0];
                    default:      ax_reg  <= ax_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        dt_reg   <= dt_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        ux_reg   <= ux_next;
        uy_reg   <= uy_next;
        sq_reg   <= sq_next;
        r_reg    <= r_next;
        acc_reg  <= acc_next;
        prod_reg <= mul_a * mul_b;
    end

    assign cfg_ready   = 1'b1;
    assign m_pos_x     = bx_reg;
    assign m_pos_y     = by_reg;
    assign m_vel_x     = bvx_reg;
    assign m_vel_y     = bvy_reg;
    assign m_pulled    = pulled_reg;
    assign m_saturated = sat_reg;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the gravity body step core: directed table, then random phases.
`timescale 1ns / 100ps

module testbench;
    import gbs_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               pulled;
        logic               sat;
    } body_state_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        op;
        logic [15:0] dt;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic        typed;
        body_state_t want;
    } stim_row_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic s_opcode;
    logic [15:0] s_time_step;
    logic signed [31:0] s_load_x, s_load_y, s_load_vx, s_load_vy;
    logic m_valid;
    logic m_ready;
    logic signed [31:0] m_pos_x, m_pos_y, m_vel_x, m_vel_y;
    logic m_pulled, m_saturated;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    gravity_body_step_core u_dut (.*);

    logic signed [31:0] attr_x, attr_y;
    logic [31:0] strength;
    logic [15:0] cutoff;
    body_state_t body;
    body_state_t pending_states[$];
    int mismatches;
    int cycles;
    bit quiet;
    int ready_stall;
    stim_row_t rows[$];

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic signed [31:0] clip_word(input logic signed [63:0] v,
                                                     inout logic flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [32:0] floor_root(input logic [65:0] s);
        logic [69:0] rem;
        logic [69:0] trial;
        logic [34:0] root;
        rem = '0;
        root = '0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | 70'(s[2*i +: 2]);
            trial = (70'(root) << 2) | 70'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 35'd1;
            end else begin
                root = root << 1;
            end
        end
        return root[32:0];
    endfunction

    function automatic logic signed [31:0] pull_velocity(input logic signed [31:0] v,
            input logic signed [63:0] d, input logic [63:0] acc, input logic [15:0] dt,
            input logic [32:0] r, inout logic flag);
        logic [63:0] mag;
        logic [127:0] prod;
        logic [127:0] q;
        logic [63:0] dv;
        mag = (d < 0) ? -d : d;
        prod = 128'(mag) * 128'(dt) * 128'(acc);
        q = (prod / 128'(r)) >> 16;
        dv = (q > 128'(64'd1 << 40)) ? (64'd1 << 40) : q[63:0];
        if (d < 0) begin
            return clip_word(64'(v) - $signed(dv), flag);
        end
        return clip_word(64'(v) + $signed(dv), flag);
    endfunction

    function automatic logic signed [31:0] move_position(input logic signed [31:0] p,
            input logic signed [31:0] v, input logic [15:0] dt, inout logic flag);
        logic signed [63:0] prod;
        logic signed [63:0] stride;
        prod = 64'(v) * $signed({48'd0, dt});
        stride = (prod >= 0) ? (prod >>> 16) : -((-prod) >>> 16);
        return clip_word(64'(p) + stride, flag);
    endfunction

    // Computes the body copy after one item and returns the state the core must report.
    function automatic body_state_t advance_body(input logic op, input logic [15:0] dt,
            input logic [31:0] lx, input logic [31:0] ly, input logic [31:0] lvx,
            input logic [31:0] lvy);
        logic signed [63:0] dx, dy;
        logic [63:0] ux, uy;
        logic [65:0] sq;
        logic [32:0] r;
        logic [127:0] a;
        logic [63:0] acc;
        logic flag;
        body_state_t res;
        res = body;
        res.pulled = 1'b0;
        res.sat = 1'b0;
        flag = 1'b0;
        if (op == OPC_LOAD) begin
            res.px = lx;
            res.py = ly;
            res.vx = lvx;
            res.vy = lvy;
        end else begin
            dx = 64'(attr_x) - 64'(body.px);
            dy = 64'(attr_y) - 64'(body.py);
            ux = (dx < 0) ? -dx : dx;
            uy = (dy < 0) ? -dy : dy;
            sq = 66'(ux) * 66'(ux) + 66'(uy) * 66'(uy);
            r = floor_root(sq);
            if (r != 0 && r >= {1'b0, cutoff, 16'd0}) begin
                a = ((128'(strength) << (3 * FRAC_BITS_DEF)) / 128'(r)) / 128'(r);
                acc = (a[127:64] != 0) ? '1 : a[63:0];
                res.pulled = 1'b1;
                res.vx = pull_velocity(body.vx, dx, acc, dt, r, flag);
                res.vy = pull_velocity(body.vy, dy, acc, dt, r, flag);
            end
            res.px = move_position(body.px, res.vx, dt, flag);
            res.py = move_position(body.py, res.vy, dt, flag);
        end
        res.sat = flag;
        return res;
    endfunction

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Mismatch on %s: expected %h, got %h", name, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin
        body_state_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_states.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Result beat with nothing pending: pos %h %h", m_pos_x, m_pos_y);
                end
            end else begin
                want = pending_states.pop_front();
                report_field("pos_x", want.px, m_pos_x);
                report_field("pos_y", want.py, m_pos_y);
                report_field("vel_x", want.vx, m_vel_x);
                report_field("vel_y", want.vy, m_vel_y);
                report_field("pulled", 32'(want.pulled), 32'(m_pulled));
                report_field("saturated", 32'(want.sat), 32'(m_saturated));
            end
        end
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (ready_stall > 0) begin
            ready_stall <= ready_stall - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            ready_stall <= $urandom_range(0, 6);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_item(input logic op, input logic [15:0] dt, input logic [31:0] lx,
            input logic [31:0] ly, input logic [31:0] lvx, input logic [31:0] lvy,
            input logic typed, input body_state_t want);
        body_state_t got;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_time_step <= dt;
        s_load_x <= lx;
        s_load_y <= ly;
        s_load_vx <= lvx;
        s_load_vy <= lvy;
        do @(posedge aclk); while (!s_ready);
        got = advance_body(op, dt, lx, ly, lvx, lvy);
        body = got;
        pending_states.push_back(typed ? want : got);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        s_valid <= 1'b0;
        while (pending_states.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ATTR_X: attr_x = data;
            CFG_ATTR_Y: attr_y = data;
            CFG_STRENGTH: strength = data;
            default: cutoff = data[15:0];
        endcase
    endtask

    function automatic stim_row_t make_row(input row_kind_t kind, input logic op,
            input logic [15:0] dt, input logic [31:0] a, input logic [31:0] b,
            input logic [31:0] c, input logic [31:0] d, input logic typed,
            input logic [31:0] ea, input logic [31:0] eb, input logic [31:0] ec,
            input logic [31:0] ed, input logic ep);
        stim_row_t row;
        row.kind = kind;
        row.op = op;
        row.dt = dt;
        row.a = a;
        row.b = b;
        row.c = c;
        row.d = d;
        row.typed = typed;
        row.want = '{ea, eb, ec, ed, ep, 1'b0};
        return row;
    endfunction

    function automatic stim_row_t load_row(input logic [31:0] x, input logic [31:0] y,
            input logic [31:0] vx, input logic [31:0] vy);
        return make_row(ROW_ITEM, OPC_LOAD, 16'h0, x, y, vx, vy, 1'b1, x, y, vx, vy, 1'b0);
    endfunction

    function automatic stim_row_t step_row(input logic [15:0] dt);
        return make_row(ROW_ITEM, OPC_STEP, dt, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0, 1'b0);
    endfunction

    function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [31:0] data);
        return make_row(ROW_CFG, OPC_STEP, 16'h0, 32'(idx), data, 0, 0, 1'b0,
                        0, 0, 0, 0, 1'b0);
    endfunction

    task automatic random_phase(input int count);
        logic [31:0] x, y, vx, vy;
        logic [15:0] dt;
        int done;
        done = 0;
        while (done < count) begin
            if ($urandom_range(0, 7) == 0) begin
                x = $urandom;
                y = $urandom;
                vx = $urandom;
                vy = $urandom;
            end else begin
                x = attr_x + $signed($urandom_range(0, 32'h07FF_FFFF) - 32'h03FF_FFFF);
                y = attr_y + $signed($urandom_range(0, 32'h07FF_FFFF) - 32'h03FF_FFFF);
                vx = $signed($urandom_range(0, 32'h01FF_FFFF) - 32'h00FF_FFFF);
                vy = $signed($urandom_range(0, 32'h01FF_FFFF) - 32'h00FF_FFFF);
            end
            send_item(OPC_LOAD, 16'($urandom), x, y, vx, vy, 1'b0, '0);
            done++;
            repeat ($urandom_range(2, 10)) begin
                case ($urandom_range(0, 9))
                    0: dt = 16'h0000;
                    1: dt = 16'hFFFF;
                    default: dt = 16'($urandom);
                endcase
                send_item(OPC_STEP, dt, $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
                done++;
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_opcode = OPC_STEP;
        s_time_step = '0;
        s_load_x = '0;
        s_load_y = '0;
        s_load_vx = '0;
        s_load_vy = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ATTR_X;
        cfg_data = '0;
        mismatches = 0;
        cycles = 0;
        quiet = 1'b0;
        ready_stall = 0;
        attr_x = ATTR_X_RST;
        attr_y = ATTR_Y_RST;
        strength = STRENGTH_RST;
        cutoff = CUTOFF_RST;
        body = '{BODY_X_RST, BODY_Y_RST, BODY_VX_RST, BODY_VY_RST, 1'b0, 1'b0};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rows.push_back(make_row(ROW_ITEM, OPC_STEP, 16'h0, 0, 0, 0, 0, 1'b1,
                                BODY_X_RST, BODY_Y_RST, BODY_VX_RST, BODY_VY_RST, 1'b1));
        rows.push_back(step_row(16'hFFFF));
        rows.push_back(load_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        rows.push_back(step_row(16'hFFFF));
        rows.push_back(load_row(ATTR_X_RST, ATTR_Y_RST, 0, 0));
        rows.push_back(make_row(ROW_ITEM, OPC_STEP, 16'hFFFF, 0, 0, 0, 0, 1'b1,
                                ATTR_X_RST, ATTR_Y_RST, 0, 0, 1'b0));
        rows.push_back(cfg_row(CFG_CUTOFF, 32'd0));
        rows.push_back(make_row(ROW_ITEM, OPC_STEP, 16'h0001, 0, 0, 0, 0, 1'b1,
                                ATTR_X_RST, ATTR_Y_RST, 0, 0, 1'b0));
        rows.push_back(cfg_row(CFG_STRENGTH, 32'hFFFF_FFFF));
        rows.push_back(load_row(ATTR_X_RST + 1, ATTR_Y_RST, 0, 0));
        rows.push_back(step_row(16'hFFFF));
        rows.push_back(load_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        rows.push_back(step_row(16'h8000));
        rows.push_back(cfg_row(CFG_ATTR_X, 32'h7FFF_FFFF));
        rows.push_back(cfg_row(CFG_ATTR_Y, 32'h8000_0000));
        rows.push_back(step_row(16'h0001));
        rows.push_back(cfg_row(CFG_CUTOFF, 32'h0000_FFFF));
        rows.push_back(step_row(16'h5555));
        rows.push_back(cfg_row(CFG_ATTR_X, ATTR_X_RST));
        rows.push_back(cfg_row(CFG_ATTR_Y, ATTR_Y_RST));
        rows.push_back(cfg_row(CFG_STRENGTH, STRENGTH_RST));
        rows.push_back(cfg_row(CFG_CUTOFF, 32'(CUTOFF_RST)));
        rows.push_back(load_row(0, 0, 0, 0));
        rows.push_back(step_row(16'h1234));

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                write_register(rows[i].a[1:0], rows[i].b);
            end else begin
                send_item(rows[i].op, rows[i].dt, rows[i].a, rows[i].b, rows[i].c, rows[i].d,
                          rows[i].typed, rows[i].want);
            end
        end

        random_phase(120);
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    write_register(CFG_CUTOFF, 32'd0);
                    write_register(CFG_STRENGTH, 32'hFFFF_FFFF);
                end
                1: begin
                    write_register(CFG_CUTOFF, 32'h0000_FFFF);
                    write_register(CFG_STRENGTH, 32'd0);
                end
                2: begin
                    write_register(CFG_ATTR_X, 32'h7FFF_FFFF);
                    write_register(CFG_ATTR_Y, 32'h8000_0000);
                    write_register(CFG_CUTOFF, 32'd1);
                end
                3: begin
                    write_register(CFG_ATTR_X, 32'h8000_0000);
                    write_register(CFG_ATTR_Y, 32'h7FFF_FFFF);
                    write_register(CFG_STRENGTH, 32'h0001_0000);
                end
                default: begin
                    write_register(CFG_ATTR_X, $urandom);
                    write_register(CFG_ATTR_Y, $urandom);
                    write_register(CFG_STRENGTH, $urandom);
                    write_register(CFG_CUTOFF, $urandom_range(0, 400));
                end
            endcase
            if (p == 7) begin
                quiet = 1'b1;
            end
            random_phase(110);
        end

        s_valid <= 1'b0;
        while (pending_states.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/gbs_pkg.sv
design/gbs_iter_unit.sv
design/gravity_body_step_core.sv
tb/testbench.sv
